// ===== rtl/gcfl_pkg.sv =====
// package for the growable cell free list
// constants, codes and controller/datapath interface types; no dependencies
`default_nettype none

package gcfl_pkg;

    localparam int MAX_BLOCKS      = 8;
    localparam int CELLS_PER_BLOCK = 64;

    localparam int CELL_W     = 9;
    localparam int COUNT_W    = 10;
    localparam int LINK_DEPTH = 512;
    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

    localparam int BLK_W  = $clog2(MAX_BLOCKS + 1);
    localparam int GROW_W = (CELLS_PER_BLOCK > 1) ? $clog2(CELLS_PER_BLOCK) : 1;

    localparam int IN_TDATA_W  = 16;
    localparam int OUT_TDATA_W = 24;
    localparam int OUT_PAD_W   = OUT_TDATA_W - CELL_W - COUNT_W;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 10;
    localparam logic [CFG_IDX_W-1:0] REG_LIFO_MODE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_FREE  = 2'd1;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    localparam logic ST_OK   = 1'b0;
    localparam logic ST_FAIL = 1'b1;

    typedef struct packed {
        logic free_push;
        logic grow_start;
        logic grow_step;
        logic pop;
        logic load_out;
        logic fail;
    } t_dp_cmd;

    typedef struct packed {
        logic need_grow;
        logic can_grow;
        logic grow_last;
        logic out_free;
    } t_dp_stat;

endpackage

`default_nettype wire

// ===== rtl/gcfl_ram.sv =====
// generic single write port, single read port ram with registered read
// no dependencies
`default_nettype none

module gcfl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

// ===== rtl/gcfl_ctrl.sv =====
// controller state machine of the growable cell free list
// depends on gcfl_pkg
`default_nettype none

module gcfl_ctrl
    import gcfl_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_in_accept,
    input  wire logic     i_in_op,
    input  wire t_dp_stat i_stat,
    output logic          o_in_ready,
    output t_dp_cmd       o_cmd
);

    localparam logic [2:0] S_IDLE      = 3'd0;
    localparam logic [2:0] S_CHECK     = 3'd1;
    localparam logic [2:0] S_GROW      = 3'd2;
    localparam logic [2:0] S_POP       = 3'd3;
    localparam logic [2:0] S_RESP_OK   = 3'd4;
    localparam logic [2:0] S_RESP_FAIL = 3'd5;

    logic [2:0] r_state;
    logic [2:0] n_state;
    logic [2:0] w_decide;

    assign o_in_ready = (r_state == S_IDLE);

    // allocation decision: grow, fail or pop
    always_comb begin
        if (i_stat.need_grow) begin
            w_decide = i_stat.can_grow ? S_GROW : S_RESP_FAIL;
        end else begin
            w_decide = S_POP;
        end
    end

    always_comb begin
        o_cmd   = '0;
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_accept) begin
                    if (i_in_op == OP_FREE) begin
                        o_cmd.free_push = 1'b1;
                        n_state         = S_RESP_OK;
                    end else begin
                        o_cmd.grow_start = (w_decide == S_GROW);
                        n_state          = w_decide;
                    end
                end
            end
            S_CHECK: begin
                o_cmd.grow_start = (w_decide == S_GROW);
                n_state          = w_decide;
            end
            S_GROW: begin
                o_cmd.grow_step = 1'b1;
                if (i_stat.grow_last) begin
                    n_state = S_CHECK;
                end
            end
            S_POP: begin
                o_cmd.pop = 1'b1;
                n_state   = S_RESP_OK;
            end
            S_RESP_OK: begin
                if (i_stat.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            S_RESP_FAIL: begin
                if (i_stat.out_free) begin
                    o_cmd.load_out = 1'b1;
                    o_cmd.fail     = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/gcfl_dp.sv =====
// datapath: list pointers, counters, config registers, link ram, output register
// depends on gcfl_pkg and gcfl_ram
`default_nettype none

module gcfl_dp
    import gcfl_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire t_dp_cmd               i_cmd,
    output t_dp_stat                   o_stat,
    input  wire logic [CELL_W-1:0]     i_cell,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    input  wire logic                  i_out_ready,
    output logic                       o_out_valid,
    output logic                       o_out_status,
    output logic      [CELL_W-1:0]     o_out_granted,
    output logic      [COUNT_W-1:0]    o_out_total
);

    logic [CELL_W-1:0]  r_head;
    logic [CELL_W-1:0]  r_tail;
    logic               r_empty;
    logic [COUNT_W-1:0] r_free_cells;
    logic [BLK_W-1:0]   r_blocks;
    logic [CELL_W-1:0]  r_next_cell;
    logic [GROW_W-1:0]  r_grow_cnt;
    logic [CELL_W-1:0]  r_grant_hold;
    logic               r_lifo_mode;
    logic [COUNT_W-1:0] r_min_free;
    logic               r_out_valid;

    logic               w_we;
    logic [CELL_W-1:0]  w_waddr;
    logic [CELL_W-1:0]  w_wdata;
    logic [CELL_W-1:0]  w_rdata;
    logic [COUNT_W-1:0] w_count_up;
    logic [COUNT_W-1:0] w_count_dn;

    assign w_count_up = (r_free_cells == COUNT_MAX) ? r_free_cells
                                                    : r_free_cells + COUNT_W'(1);
    assign w_count_dn = (r_free_cells == '0) ? r_free_cells
                                             : r_free_cells - COUNT_W'(1);

    assign o_stat.need_grow = r_empty || (r_free_cells < r_min_free);
    assign o_stat.can_grow  = (r_blocks < BLK_W'(MAX_BLOCKS));
    assign o_stat.grow_last = (r_grow_cnt == '0);
    assign o_stat.out_free  = !r_out_valid || i_out_ready;

    // link ram write port
    always_comb begin
        w_we    = 1'b0;
        w_waddr = r_tail;
        w_wdata = i_cell;
        if (i_cmd.free_push) begin
            w_we = !r_empty;
            if (r_lifo_mode) begin
                w_waddr = i_cell;
                w_wdata = r_head;
            end
        end else if (i_cmd.grow_step) begin
            w_we    = !r_empty;
            w_wdata = r_next_cell;
        end
    end

    gcfl_ram #(
        .WIDTH (CELL_W),
        .DEPTH (LINK_DEPTH)
    ) u_link_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (r_head),
        .o_rdata (w_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head       <= '0;
            r_tail       <= '0;
            r_empty      <= 1'b1;
            r_free_cells <= '0;
            r_blocks     <= '0;
            r_next_cell  <= '0;
            r_lifo_mode  <= 1'b0;
            r_min_free   <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_index == REG_LIFO_MODE) begin
                    r_lifo_mode <= i_cfg_data[0];
                end else if (i_cfg_index == REG_MIN_FREE) begin
                    r_min_free <= i_cfg_data[COUNT_W-1:0];
                end
            end
            if (i_cmd.free_push) begin
                r_free_cells <= w_count_up;
                r_empty      <= 1'b0;
                if (r_lifo_mode) begin
                    r_head <= i_cell;
                    if (r_empty) begin
                        r_tail <= i_cell;
                    end
                end else begin
                    r_tail <= i_cell;
                    if (r_empty) begin
                        r_head <= i_cell;
                    end
                end
            end
            if (i_cmd.grow_step) begin
                r_free_cells <= w_count_up;
                r_empty      <= 1'b0;
                r_tail       <= r_next_cell;
                r_next_cell  <= r_next_cell + CELL_W'(1);
                if (r_empty) begin
                    r_head <= r_next_cell;
                end
                if (r_grow_cnt == '0) begin
                    r_blocks <= r_blocks + BLK_W'(1);
                end
            end
            if (i_cmd.pop) begin
                r_free_cells <= w_count_dn;
                if (r_head == r_tail) begin
                    r_empty <= 1'b1;
                end else begin
                    r_head <= w_rdata;
                end
            end
            if (i_cmd.load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.grow_start) begin
            r_grow_cnt <= GROW_W'(CELLS_PER_BLOCK - 1);
        end else if (i_cmd.grow_step) begin
            r_grow_cnt <= r_grow_cnt - GROW_W'(1);
        end
        if (i_cmd.free_push) begin
            r_grant_hold <= '0;
        end else if (i_cmd.pop) begin
            r_grant_hold <= r_head;
        end
        if (i_cmd.load_out) begin
            o_out_status  <= i_cmd.fail ? ST_FAIL : ST_OK;
            o_out_granted <= i_cmd.fail ? '0 : r_grant_hold;
            o_out_total   <= r_free_cells;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

`default_nettype wire

// ===== rtl/growable_cell_free_list.sv =====
// top level of the growable cell free list allocator
// depends on gcfl_pkg, gcfl_ctrl and gcfl_dp
//
// channel  | direction | handshake                      | payload
// s_axis   | in        | s_axis_tvalid / s_axis_tready  | tuser operation, tdata cell_index
// m_axis   | out       | m_axis_tvalid / m_axis_tready  | tuser status, tdata granted, total
// cfg      | in        | i_cfg_valid / o_cfg_ready      | i_cfg_index, i_cfg_data
//
// free: the cell is pushed on accept; the result word loads in S_RESP_OK, then input is ready again
// allocate without growth: pop in S_POP, result word in S_RESP_OK; one request at a time
// each growth adds CELLS_PER_BLOCK cells in S_GROW (each linked behind the tail), then S_CHECK
// a pop takes the next head from the registered read of the link ram
// sync active-low reset empties the list; link ram contents are not cleared
// a stalled result holds in the output register; the next word's result waits behind it
`default_nettype none

module growable_cell_free_list
    import gcfl_pkg::*;
(
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   s_axis_tvalid,
    output logic                        s_axis_tready,
    input  wire logic                   s_axis_tuser,   // [0] operation
    input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata,   // [8:0] cell_index, rest zero
    output logic                        m_axis_tvalid,
    input  wire logic                   m_axis_tready,
    output logic                        m_axis_tuser,   // [0] status
    output logic      [OUT_TDATA_W-1:0] m_axis_tdata,   // [8:0] granted_cell, [18:9] free_total
    input  wire logic                   i_cfg_valid,
    output logic                        o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]   i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  i_cfg_data
);

    t_dp_cmd            w_cmd;
    t_dp_stat           w_stat;
    logic               w_in_accept;
    logic [CELL_W-1:0]  w_granted;
    logic [COUNT_W-1:0] w_total;

    assign w_in_accept = s_axis_tvalid && s_axis_tready;
    assign o_cfg_ready = 1'b1;
    assign m_axis_tdata = {{OUT_PAD_W{1'b0}}, w_total, w_granted};

    gcfl_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_accept (w_in_accept),
        .i_in_op     (s_axis_tuser),
        .i_stat      (w_stat),
        .o_in_ready  (s_axis_tready),
        .o_cmd       (w_cmd)
    );

    gcfl_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .o_stat        (w_stat),
        .i_cell        (s_axis_tdata[CELL_W-1:0]),
        .i_cfg_we      (i_cfg_valid),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_out_ready   (m_axis_tready),
        .o_out_valid   (m_axis_tvalid),
        .o_out_status  (m_axis_tuser),
        .o_out_granted (w_granted),
        .o_out_total   (w_total)
    );

endmodule

`default_nettype wire

// ===== rtl/gcfl_chk.sv =====
// port-level checker for growable_cell_free_list, bound to the top level
// depends on gcfl_pkg
`default_nettype none

module gcfl_chk
    import gcfl_pkg::*;
(
    input wire logic                   i_clk,
    input wire logic                   i_rst_n,
    input wire logic                   s_axis_tvalid,
    input wire logic                   s_axis_tready,
    input wire logic                   m_axis_tvalid,
    input wire logic                   m_axis_tready,
    input wire logic                   m_axis_tuser,
    input wire logic [OUT_TDATA_W-1:0] m_axis_tdata
);

    // no result word right after reset
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid after reset");

    // stalled result word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("stalled result changed");

    // failed allocation grants no cell
    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tuser == ST_FAIL) |-> m_axis_tdata[CELL_W-1:0] == '0)
        else $error("failed allocation with nonzero cell");

    // one request at a time: busy right after an accepted word
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input ready right after accept");

endmodule

bind growable_cell_free_list gcfl_chk u_gcfl_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire
